[design/xfpr_pkg.sv]
// xfpr_pkg: shared types and constants for the XOR framed packet receiver.
// No dependencies; imported by xor_framed_packet_receiver.
`default_nettype none

package xfpr_pkg;

  localparam int unsigned ByteW = 8;

  typedef logic [ByteW-1:0] byte_t;

  localparam logic CfgIdxStartByte = 1'b0;
  localparam logic CfgIdxMaxLength = 1'b1;

  localparam byte_t StartByteReset = 8'h53;
  localparam byte_t MaxLengthReset = 8'd32;

  localparam logic KindData     = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  typedef enum logic [5:0] {
    PH_HUNT = 6'b000001,
    PH_SEQ  = 6'b000010,
    PH_CMD  = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_XOR  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic  kind;
    byte_t seq_num;
    byte_t command_code;
    byte_t payload_length;
    byte_t data_byte;
    byte_t data_index;
    logic  checksum_ok;
  } result_t;

endpackage

`default_nettype wire

[design/xor_framed_packet_receiver.sv]
// xor_framed_packet_receiver: deframes a length-prefixed byte stream with an XOR check.
// Depends on xfpr_pkg for types, phase codes and register indexes.
`default_nettype none

// Usage:
//   Input channel rx_valid/rx_ready/rx_byte carries one received byte per transaction.
//   Output channel out_valid/out_ready carries one result per data byte (kind 0,
//   with data_byte and data_index) and one frame-end summary per frame (kind 1,
//   with checksum_ok); header bytes, the start byte and dropped frames give none.
//   A frame is start byte, sequence, command, length, data bytes, XOR byte.
//   Lengths above max_length drop the frame and the receiver hunts again.
//   Latency: a result appears in the cycle after its byte is accepted.
//   Throughput: one byte per cycle unless stalled; output register is the only stage.
//   rx_ready is high whenever the output register is empty or being taken,
//   so a stalled receiver holds one result and stops input after that.
//   cfg_we writes start_byte (index 0) or max_length (index 1) at once.
//   Reset (rst, synchronous): start_byte 0x53, max_length 32, hunting,
//   header holds, byte count and running XOR cleared, output empty.

module xor_framed_packet_receiver (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_we,
  input  wire logic           cfg_index,
  input  wire xfpr_pkg::byte_t cfg_data,
  input  wire logic           rx_valid,
  output logic                rx_ready,
  input  wire xfpr_pkg::byte_t rx_byte,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                kind,
  output xfpr_pkg::byte_t     seq_num,
  output xfpr_pkg::byte_t     command_code,
  output xfpr_pkg::byte_t     payload_length,
  output xfpr_pkg::byte_t     data_byte,
  output xfpr_pkg::byte_t     data_index,
  output logic                checksum_ok
);
  import xfpr_pkg::*;

  byte_t   start_byte;
  byte_t   max_length;
  phase_t  phase, phase_next;
  byte_t   seq_hold, seq_hold_next;
  byte_t   command_hold, command_hold_next;
  byte_t   length_hold, length_hold_next;
  byte_t   byte_count, byte_count_next;
  byte_t   running_xor, running_xor_next;
  result_t result, result_next;
  logic    emit;
  logic    accept;

  assign rx_ready = !out_valid || out_ready;
  assign accept   = rx_valid && rx_ready;

  always_comb begin
    phase_next        = phase;
    seq_hold_next     = seq_hold;
    command_hold_next = command_hold;
    length_hold_next  = length_hold;
    byte_count_next   = byte_count;
    running_xor_next  = running_xor;
    emit              = 1'b0;
    result_next       = '{kind: KindData, seq_num: seq_hold, command_code: command_hold,
                          payload_length: length_hold, data_byte: '0, data_index: '0,
                          checksum_ok: 1'b0};
    unique case (phase)
      PH_SEQ: begin
        seq_hold_next    = rx_byte;
        running_xor_next = running_xor ^ rx_byte;
        phase_next       = PH_CMD;
      end
      PH_CMD: begin
        command_hold_next = rx_byte;
        running_xor_next  = running_xor ^ rx_byte;
        phase_next        = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte > max_length) begin
          phase_next = PH_HUNT;
        end else begin
          length_hold_next = rx_byte;
          running_xor_next = running_xor ^ rx_byte;
          phase_next       = (rx_byte != '0) ? PH_DATA : PH_XOR;
        end
      end
      PH_DATA: begin
        emit                   = 1'b1;
        result_next.data_byte  = rx_byte;
        result_next.data_index = byte_count;
        running_xor_next       = running_xor ^ rx_byte;
        byte_count_next        = byte_count + 8'd1;
        if (byte_count_next >= length_hold) begin
          phase_next = PH_XOR;
        end
      end
      PH_XOR: begin
        emit                    = 1'b1;
        result_next.kind        = KindFrameEnd;
        result_next.checksum_ok = (rx_byte == running_xor);
        phase_next              = PH_HUNT;
      end
      default: begin
        if (rx_byte == start_byte) begin
          byte_count_next  = '0;
          running_xor_next = rx_byte;
          phase_next       = PH_SEQ;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= StartByteReset;
      max_length <= MaxLengthReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgIdxStartByte: start_byte <= cfg_data;
        CfgIdxMaxLength: max_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      seq_hold     <= '0;
      command_hold <= '0;
      length_hold  <= '0;
      byte_count   <= '0;
      running_xor  <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      seq_hold     <= seq_hold_next;
      command_hold <= command_hold_next;
      length_hold  <= length_hold_next;
      byte_count   <= byte_count_next;
      running_xor  <= running_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rx_ready) begin
      out_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= result_next;
    end
  end

  assign kind           = result.kind;
  assign seq_num        = result.seq_num;
  assign command_code   = result.command_code;
  assign payload_length = result.payload_length;
  assign data_byte      = result.data_byte;
  assign data_index     = result.data_index;
  assign checksum_ok    = result.checksum_ok;

endmodule

`default_nettype wire
